>>> hw/rtl/dchm_pkg.sv
// ----------------------------------------------------------------------------
// dchm_pkg: shared definitions for the duty cycle hysteresis meter
// Default widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dchm_pkg;

    localparam int TIME_WIDTH_DEFAULT    = 48;
    localparam int VALUE_WIDTH_DEFAULT   = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_LEVEL     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_LEVEL    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_OFFSET = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_START = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WINDOW,
        ST_LEVEL,
        ST_STEP,
        ST_ACCUM,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_result;
    } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dchm_if.sv
// ----------------------------------------------------------------------------
// dchm interfaces: sample, result and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface dchm_sample_if #(
    parameter int TIME_WIDTH  = dchm_pkg::TIME_WIDTH_DEFAULT,
    parameter int VALUE_WIDTH = dchm_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic [TIME_WIDTH-1:0]         sample_time;
    logic signed [VALUE_WIDTH-1:0] sample_value;

    modport source (output valid, sample_time, sample_value, input ready);
    modport sink   (input valid, sample_time, sample_value, output ready);
endinterface

interface dchm_result_if #(
    parameter int TIME_WIDTH    = dchm_pkg::TIME_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = dchm_pkg::FRACTION_BITS_DEFAULT
);
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS:0]   duty_fraction;
    logic                     measure_valid;
    logic                     is_on;
    logic [TIME_WIDTH-1:0]    on_total;
    logic [TIME_WIDTH-1:0]    window_total;

    modport source (output valid, duty_fraction, measure_valid, is_on, on_total,
                    window_total, input ready);
    modport sink   (input valid, duty_fraction, measure_valid, is_on, on_total,
                    window_total, output ready);
endinterface

interface dchm_cfg_if #(
    parameter int DATA_WIDTH = dchm_pkg::TIME_WIDTH_DEFAULT
);
    logic                                 valid;
    logic                                 ready;
    logic [dchm_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]                data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/duty_cycle_hysteresis_meter.sv
// ----------------------------------------------------------------------------
// duty_cycle_hysteresis_meter: windowed duty cycle with level hysteresis
//
// Channels: sample (sink) takes a timestamp and a signed value; result
// (source) returns one word per sample with the duty fraction, valid flag,
// hysteresis state and both time totals; cfg (sink) writes the five
// registers (on level, off level, offset, window start, window end) and is
// always ready; write it only while the meter is idle.
// Sequence: an accepted sample passes the window, level, step and accumulate
// states, then the restoring divider, which retires one quotient bit per
// cycle on a shared subtractor, then loads the result register. An empty
// window or a full fraction skips the divide. One sample is processed at a
// time; sample ready is high only when idle.
// Stall: the result sits in an output register; the next sample is accepted
// while it waits, and that sample holds in its last step until the register
// is free.
// Reset: totals, state, and the started, on and output valid flags clear;
// window end goes to all ones, levels and offset go to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module duty_cycle_hysteresis_meter #(
    parameter int TIME_WIDTH    = dchm_pkg::TIME_WIDTH_DEFAULT,
    parameter int VALUE_WIDTH   = dchm_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = dchm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    dchm_sample_if.sink         sample,
    dchm_result_if.source       result,
    dchm_cfg_if.sink            cfg
);

    localparam int CNT_W = $clog2(FRACTION_BITS);

    // configuration
    logic signed [VALUE_WIDTH-1:0] on_level_reg;
    logic signed [VALUE_WIDTH-1:0] off_level_reg;
    logic signed [VALUE_WIDTH-1:0] level_offset_reg;
    logic [TIME_WIDTH-1:0]         window_start_reg;
    logic [TIME_WIDTH-1:0]         window_end_reg;

    // meter state
    logic [TIME_WIDTH-1:0] previous_time_reg;
    logic                  started_reg;
    logic                  on_flag_reg;
    logic [TIME_WIDTH-1:0] on_acc_reg;
    logic [TIME_WIDTH-1:0] win_acc_reg;

    // working registers
    dchm_pkg::state_t              state_reg, state_next;
    logic [TIME_WIDTH-1:0]         time_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH:0]   vsum_reg;
    logic                          counted_reg;
    logic                          on_reg;
    logic [TIME_WIDTH-1:0]         step_reg;
    logic [TIME_WIDTH-1:0]         rem_reg;
    logic [FRACTION_BITS:0]        quo_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          meas_valid_reg;

    // result register
    logic                   out_valid_reg;
    logic [FRACTION_BITS:0] out_frac_reg;
    logic                   out_mvalid_reg;
    logic                   out_on_reg;
    logic [TIME_WIDTH-1:0]  out_on_total_reg;
    logic [TIME_WIDTH-1:0]  out_win_total_reg;

    dchm_pkg::ctrl_t ctrl;

    logic                    in_fire;
    logic                    out_fire;
    logic                    cfg_fire;
    logic [TIME_WIDTH:0]     on_sum;
    logic [TIME_WIDTH:0]     win_sum;
    logic [TIME_WIDTH-1:0]   on_sat;
    logic [TIME_WIDTH-1:0]   win_sat;
    logic [TIME_WIDTH:0]     rem_shift;
    logic [TIME_WIDTH:0]     rem_diff;
    logic                    rem_ge;
    logic signed [VALUE_WIDTH:0] on_ext;
    logic signed [VALUE_WIDTH:0] off_ext;

    assign in_fire  = sample.valid && ctrl.in_ready;
    assign out_fire = out_valid_reg && result.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    assign sample.ready = ctrl.in_ready;
    assign cfg.ready    = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.duty_fraction = out_frac_reg;
    assign result.measure_valid = out_mvalid_reg;
    assign result.is_on         = out_on_reg;
    assign result.on_total      = out_on_total_reg;
    assign result.window_total  = out_win_total_reg;

    // saturating accumulators
    assign on_sum  = {1'b0, on_acc_reg} + {1'b0, step_reg};
    assign win_sum = {1'b0, win_acc_reg} + {1'b0, step_reg};
    assign on_sat  = on_sum[TIME_WIDTH] ? '1 : on_sum[TIME_WIDTH-1:0];
    assign win_sat = win_sum[TIME_WIDTH] ? '1 : win_sum[TIME_WIDTH-1:0];

    // shared divider subtractor
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, win_acc_reg};
    assign rem_ge    = rem_shift >= {1'b0, win_acc_reg};

    assign on_ext  = {on_level_reg[VALUE_WIDTH-1], on_level_reg};
    assign off_ext = {off_level_reg[VALUE_WIDTH-1], off_level_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dchm_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = dchm_pkg::ST_WINDOW;
            end
            dchm_pkg::ST_WINDOW: state_next = dchm_pkg::ST_LEVEL;
            dchm_pkg::ST_LEVEL:  state_next = dchm_pkg::ST_STEP;
            dchm_pkg::ST_STEP:   state_next = dchm_pkg::ST_ACCUM;
            dchm_pkg::ST_ACCUM:  state_next = dchm_pkg::ST_DIVIDE;
            dchm_pkg::ST_DIVIDE:
            begin
                if (!meas_valid_reg || rem_reg == win_acc_reg || cnt_reg == '0)
                    state_next = dchm_pkg::ST_DONE;
            end
            dchm_pkg::ST_DONE:
            begin
                if (ctrl.load_result)
                    state_next = dchm_pkg::ST_IDLE;
            end
            default: state_next = dchm_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            dchm_pkg::ST_IDLE: ctrl.in_ready    = 1'b1;
            dchm_pkg::ST_DONE: ctrl.load_result = !out_valid_reg || result.ready;
            default:           ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dchm_pkg::ST_IDLE;
            on_level_reg     <= '0;
            off_level_reg    <= '0;
            level_offset_reg <= '0;
            window_start_reg <= '0;
            window_end_reg   <= '1;
            previous_time_reg <= '0;
            started_reg      <= 1'b0;
            on_flag_reg      <= 1'b0;
            on_acc_reg       <= '0;
            win_acc_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                case (cfg.index)
                    dchm_pkg::REG_ON_LEVEL:     on_level_reg <= cfg.data[VALUE_WIDTH-1:0];
                    dchm_pkg::REG_OFF_LEVEL:    off_level_reg <= cfg.data[VALUE_WIDTH-1:0];
                    dchm_pkg::REG_LEVEL_OFFSET: level_offset_reg <= cfg.data[VALUE_WIDTH-1:0];
                    dchm_pkg::REG_WINDOW_START: window_start_reg <= cfg.data[TIME_WIDTH-1:0];
                    dchm_pkg::REG_WINDOW_END:   window_end_reg <= cfg.data[TIME_WIDTH-1:0];
                    default:                    ;
                endcase
            end

            if (state_reg == dchm_pkg::ST_ACCUM && counted_reg)
            begin
                if (started_reg)
                begin
                    if (on_reg)
                        on_acc_reg <= on_sat;
                    on_flag_reg <= on_reg;
                    win_acc_reg <= win_sat;
                end
                previous_time_reg <= time_reg;
                started_reg       <= 1'b1;
            end

            if (ctrl.load_result)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dchm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    time_reg  <= sample.sample_time;
                    value_reg <= sample.sample_value;
                end
            end
            dchm_pkg::ST_WINDOW:
            begin
                counted_reg <= (time_reg >= window_start_reg) &&
                               (time_reg <= window_end_reg);
                vsum_reg <= {value_reg[VALUE_WIDTH-1], value_reg} +
                            {level_offset_reg[VALUE_WIDTH-1], level_offset_reg};
            end
            dchm_pkg::ST_LEVEL:
            begin
                on_reg <= (vsum_reg > on_ext) || (on_flag_reg && (vsum_reg > off_ext));
            end
            dchm_pkg::ST_STEP:
            begin
                step_reg <= (time_reg >= previous_time_reg) ?
                            time_reg - previous_time_reg : '0;
            end
            dchm_pkg::ST_ACCUM:
            begin
                // totals settle here; divider starts next cycle
                meas_valid_reg <= (counted_reg || started_reg) &&
                                  (counted_reg && started_reg ? win_sat != '0
                                                              : win_acc_reg != '0);
                rem_reg <= (counted_reg && started_reg && on_reg) ? on_sat : on_acc_reg;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(FRACTION_BITS - 1);
            end
            dchm_pkg::ST_DIVIDE:
            begin
                if (!meas_valid_reg)
                    quo_reg <= '0;
                else if (rem_reg == win_acc_reg)
                    quo_reg <= {1'b1, {FRACTION_BITS{1'b0}}};
                else
                begin
                    if (rem_ge)
                    begin
                        rem_reg <= rem_diff[TIME_WIDTH-1:0];
                        quo_reg <= {quo_reg[FRACTION_BITS-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[TIME_WIDTH-1:0];
                        quo_reg <= {quo_reg[FRACTION_BITS-1:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            default: ;
        endcase

        if (ctrl.load_result)
        begin
            out_frac_reg      <= quo_reg;
            out_mvalid_reg    <= meas_valid_reg;
            out_on_reg        <= on_flag_reg;
            out_on_total_reg  <= on_acc_reg;
            out_win_total_reg <= win_acc_reg;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_duty_cycle_hysteresis_meter.sv
// ----------------------------------------------------------------------------
// tb_duty_cycle_hysteresis_meter: self-checking bench for the duty cycle meter
// Feeds timestamped samples through the valid/ready sample channel and
// programs the levels, offset and time window between phases. A predictor
// tracks the hysteresis state and both time totals and computes the expected
// Q16 duty fraction for every accepted sample. Each result word is compared
// in order against that prediction. Both sides idle in random bursts, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_duty_cycle_hysteresis_meter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW      = dchm_pkg::TIME_WIDTH_DEFAULT;
    localparam int VW      = dchm_pkg::VALUE_WIDTH_DEFAULT;
    localparam int FB      = dchm_pkg::FRACTION_BITS_DEFAULT;
    localparam int IW      = dchm_pkg::CFG_INDEX_WIDTH;
    localparam int LATENCY = FB + 6;

    localparam logic [TW-1:0] TOP_TIME = '1;
    localparam logic [TW-1:0] DIR_BASE = 48'hFFFF_F000_0000;

    typedef struct packed {
        logic [TW-1:0]        stamp;
        logic signed [VW-1:0] level;
    } sample_word_t;

    typedef struct packed {
        logic [FB:0]   fraction;
        logic          measured;
        logic          on_state;
        logic [TW-1:0] on_ticks;
        logic [TW-1:0] span_ticks;
    } duty_word_t;

    logic clk = 1'b0;
    logic rst_n;

    dchm_sample_if #(.TIME_WIDTH(TW), .VALUE_WIDTH(VW)) sample_bus ();
    dchm_result_if #(.TIME_WIDTH(TW), .FRACTION_BITS(FB)) result_bus ();
    dchm_cfg_if #(.DATA_WIDTH(TW)) cfg_bus ();

    duty_cycle_hysteresis_meter #(
        .TIME_WIDTH(TW),
        .VALUE_WIDTH(VW),
        .FRACTION_BITS(FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_bus),
        .result(result_bus),
        .cfg(cfg_bus)
    );

    // predictor copy of the registers and the measurement state
    logic signed [VW-1:0] on_thresh   = '0;
    logic signed [VW-1:0] off_thresh  = '0;
    logic signed [VW-1:0] level_shift = '0;
    logic [TW-1:0]        win_open    = '0;
    logic [TW-1:0]        win_close   = '1;
    logic [TW-1:0]        last_stamp  = '0;
    logic [TW-1:0]        acc_on      = '0;
    logic [TW-1:0]        acc_span    = '0;
    logic                 armed       = 1'b0;
    logic                 lit         = 1'b0;

    sample_word_t sample_backlog[$];
    duty_word_t   duty_expected[$];

    logic sample_taken = 1'b0;
    logic calm         = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   feed_gap     = 0;
    int   drain_gap    = 0;
    int   words_seen   = 0;
    int   fault_count  = 0;

    always #5 clk = ~clk;

    function automatic logic [TW-1:0] add_ticks(input logic [TW-1:0] acc,
                                                input logic [TW-1:0] step);
        logic [TW:0] sum;
        sum = {1'b0, acc} + {1'b0, step};
        return sum[TW] ? TOP_TIME : sum[TW-1:0];
    endfunction

    function automatic logic [FB:0] duty_ratio(input logic [TW-1:0] part,
                                               input logic [TW-1:0] whole);
        logic [TW+FB-1:0] quotient;
        if (part >= whole)
            return {1'b1, {FB{1'b0}}};
        quotient = {part, {FB{1'b0}}} / {{FB{1'b0}}, whole};
        return quotient[FB:0];
    endfunction

    function automatic duty_word_t predict_duty(input sample_word_t s);
        duty_word_t           w;
        logic [TW-1:0]        step;
        logic signed [VW:0]   sum;
        logic signed [VW:0]   on_ext;
        logic signed [VW:0]   off_ext;
        logic                 now_on;
        on_ext  = on_thresh;
        off_ext = off_thresh;
        sum     = $signed(s.level);
        sum     = sum + level_shift;
        if (s.stamp >= win_open && s.stamp <= win_close)
        begin
            if (armed)
            begin
                step   = (s.stamp >= last_stamp) ? s.stamp - last_stamp : '0;
                now_on = (sum > on_ext) || (lit && sum > off_ext);
                if (now_on)
                    acc_on = add_ticks(acc_on, step);
                lit      = now_on;
                acc_span = add_ticks(acc_span, step);
            end
            last_stamp = s.stamp;
            armed      = 1'b1;
        end
        w.measured   = armed && acc_span != '0;
        w.fraction   = w.measured ? duty_ratio(acc_on, acc_span) : '0;
        w.on_state   = lit;
        w.on_ticks   = acc_on;
        w.span_ticks = acc_span;
        return w;
    endfunction

    function automatic void record_setting(input logic [IW-1:0] idx,
                                           input logic [TW-1:0] data);
        case (idx)
            dchm_pkg::REG_ON_LEVEL:     on_thresh   = data[VW-1:0];
            dchm_pkg::REG_OFF_LEVEL:    off_thresh  = data[VW-1:0];
            dchm_pkg::REG_LEVEL_OFFSET: level_shift = data[VW-1:0];
            dchm_pkg::REG_WINDOW_START: win_open    = data;
            dchm_pkg::REG_WINDOW_END:   win_close   = data;
            default: ;
        endcase
    endfunction

    // level registers are narrower than the write bus; the spare bits are junk
    function automatic logic [TW-1:0] level_word(input logic [VW-1:0] lvl);
        logic [TW-1:0] w;
        w          = TW'({$urandom, $urandom});
        w[VW-1:0]  = lvl;
        return w;
    endfunction

    function automatic void queue_sample(input logic [TW-1:0] t, input logic [VW-1:0] v);
        sample_word_t s;
        s.stamp = t;
        s.level = v;
        sample_backlog.push_back(s);
    endfunction

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [TW-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((sample_backlog.size() != 0 || sample_bus.valid ||
                duty_expected.size() != 0) && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : observe
        duty_word_t want;
        duty_word_t got;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                record_setting(cfg_bus.index, cfg_bus.data);
            if (sample_bus.valid && sample_bus.ready)
                duty_expected.push_back(
                    predict_duty({sample_bus.sample_time, sample_bus.sample_value}));
            sample_taken <= sample_bus.valid && sample_bus.ready;
            if (result_bus.valid && result_bus.ready)
            begin
                got = {result_bus.duty_fraction, result_bus.measure_valid,
                       result_bus.is_on, result_bus.on_total, result_bus.window_total};
                words_seen <= words_seen + 1;
                if (duty_expected.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("%0t: result word with no sample pending", $realtime);
                    fault_count++;
                end
                else
                begin
                    want = duty_expected.pop_front();
                    if (got !== want)
                    begin
                        if (fault_count < 10)
                        begin
                            $write("%0t: mismatch exp frac=%0d valid=%0b on=%0b ",
                                   $realtime, want.fraction, want.measured,
                                   want.on_state);
                            $write("on_total=%0d window_total=%0d, ",
                                   want.on_ticks, want.span_ticks);
                            $write("got frac=%0d valid=%0b on=%0b ",
                                   got.fraction, got.measured, got.on_state);
                            $display("on_total=%0d window_total=%0d",
                                     got.on_ticks, got.span_ticks);
                        end
                        fault_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : feed
        logic         offer;
        sample_word_t item;
        if (rst_n)
        begin
            offer = sample_bus.valid && !sample_taken;
            if (!offer)
            begin
                if (feed_gap != 0)
                    feed_gap <= feed_gap - 1;
                else if (!calm && $urandom_range(0, 5) == 0)
                    feed_gap <= $urandom_range(0, 6);
                else if (sample_backlog.size() != 0)
                begin
                    item = sample_backlog.pop_front();
                    sample_bus.sample_time  <= item.stamp;
                    sample_bus.sample_value <= item.level;
                    offer = 1'b1;
                end
            end
            sample_bus.valid <= offer;
        end
    end

    always @(negedge clk)
    begin : drain
        logic take;
        if (rst_n)
        begin
            take = 1'b1;
            if (drain_gap != 0)
            begin
                drain_gap <= drain_gap - 1;
                take = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                drain_gap <= $urandom_range(0, 6);
                take = 1'b0;
            end
            result_bus.ready <= take && hold_left == 0;
        end
    end

    // one long back-pressure stretch so the meter fills and stalls its input
    always @(negedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && words_seen >= 100)
            begin
                hold_left <= 400;
                hold_done <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int            ph;
        int            n;
        int            count;
        int            pick;
        int            lv_on;
        int            lv_off;
        int            lv_shift;
        int            lv;
        logic [TW-1:0] base;
        logic [TW-1:0] cursor;
        logic [TW-1:0] stamp;
        logic [TW-1:0] w_lo;
        logic [TW-1:0] w_hi;

        rst_n                   = 1'b0;
        sample_bus.valid        = 1'b0;
        sample_bus.sample_time  = '0;
        sample_bus.sample_value = '0;
        result_bus.ready        = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = dchm_pkg::REG_ON_LEVEL;
        cfg_bus.data            = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: first sample only arms, zero step, backward step
        queue_sample(DIR_BASE + 5, 100);
        queue_sample(DIR_BASE + 5, 100);
        queue_sample(DIR_BASE + 15, -1);
        queue_sample(DIR_BASE + 25, 1);
        queue_sample(DIR_BASE + 20, 32'h7fff_ffff);
        queue_sample(DIR_BASE + 35, 32'h8000_0000);
        wait_drained();

        // hysteresis band around a shifted sample
        write_reg(dchm_pkg::REG_ON_LEVEL, level_word(1000));
        write_reg(dchm_pkg::REG_OFF_LEVEL, level_word(-1000));
        write_reg(dchm_pkg::REG_LEVEL_OFFSET, level_word(-500));
        queue_sample(DIR_BASE + 40, 1600);
        queue_sample(DIR_BASE + 50, 0);
        queue_sample(DIR_BASE + 60, -600);
        queue_sample(DIR_BASE + 70, 1000);
        wait_drained();

        // narrow window: before, both edges, after
        write_reg(dchm_pkg::REG_WINDOW_START, DIR_BASE + 100);
        write_reg(dchm_pkg::REG_WINDOW_END, DIR_BASE + 200);
        queue_sample(DIR_BASE + 50, 5000);
        queue_sample(DIR_BASE + 100, 5000);
        queue_sample(DIR_BASE + 150, -5000);
        queue_sample(DIR_BASE + 200, 5000);
        queue_sample(DIR_BASE + 201, 5000);
        wait_drained();

        // offset sum beyond the value range
        write_reg(dchm_pkg::REG_ON_LEVEL, level_word(32'h7fff_ffff));
        write_reg(dchm_pkg::REG_OFF_LEVEL, level_word(32'h8000_0000));
        write_reg(dchm_pkg::REG_LEVEL_OFFSET, level_word(32'h7fff_ffff));
        write_reg(dchm_pkg::REG_WINDOW_START, DIR_BASE);
        write_reg(dchm_pkg::REG_WINDOW_END, TOP_TIME);
        queue_sample(DIR_BASE + 300, 32'h7fff_ffff);
        queue_sample(DIR_BASE + 310, 32'h8000_0000);
        wait_drained();
        write_reg(dchm_pkg::REG_ON_LEVEL, level_word(32'h8000_0000));
        write_reg(dchm_pkg::REG_OFF_LEVEL, level_word(32'h7fff_ffff));
        write_reg(dchm_pkg::REG_LEVEL_OFFSET, level_word(32'h8000_0000));
        queue_sample(DIR_BASE + 320, 32'h8000_0000);
        queue_sample(DIR_BASE + 330, 32'h7fff_ffff);
        wait_drained();

        // inverted window counts nothing
        write_reg(dchm_pkg::REG_WINDOW_START, DIR_BASE + 1000);
        write_reg(dchm_pkg::REG_WINDOW_END, DIR_BASE + 999);
        queue_sample(DIR_BASE + 999, 0);
        queue_sample(DIR_BASE + 1000, 0);

        // bases descend so the jump between phases is a backward (zero) step
        for (ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            if (ph == 7)
                calm = 1'b1;
            base = (TW'(7 - ph) << 45) + (TW'(1) << 40) +
                   TW'({$urandom_range(0, 255), $urandom});

            lv_on    = int'($urandom_range(0, 2 << 20)) - (1 << 20);
            lv_off   = lv_on - int'($urandom_range(0, 1 << 16));
            lv_shift = int'($urandom_range(0, 1 << 17)) - (1 << 16);
            case (ph)
                2:
                begin
                    lv_on    = 32'h7fff_ffff;
                    lv_off   = 32'h8000_0000;
                    lv_shift = $urandom;
                end
                4:
                begin
                    lv_shift = 32'h7fff_ffff;
                    lv_on    = 32'h7fff_0000;
                    lv_off   = 32'h7ff0_0000;
                end
                5: lv_off = lv_on + int'($urandom_range(1, 1 << 16));
                default: ;
            endcase

            case (ph % 4)
                0:
                begin
                    w_lo = '0;
                    w_hi = TOP_TIME;
                end
                1:
                begin
                    w_lo = base + TW'($urandom_range(0, 5000));
                    w_hi = w_lo + TW'($urandom_range(1 << 20, 1 << 26));
                end
                2:
                begin
                    w_lo = '0;
                    w_hi = base + (TW'(1) << 24);
                end
                default:
                begin
                    w_lo = base + (TW'(1) << 22);
                    w_hi = TOP_TIME;
                end
            endcase

            write_reg(dchm_pkg::REG_ON_LEVEL, level_word(lv_on));
            write_reg(dchm_pkg::REG_OFF_LEVEL, level_word(lv_off));
            write_reg(dchm_pkg::REG_LEVEL_OFFSET, level_word(lv_shift));
            write_reg(dchm_pkg::REG_WINDOW_START, w_lo);
            write_reg(dchm_pkg::REG_WINDOW_END, w_hi);

            cursor = base;
            count  = 100 + $urandom_range(0, 10);
            for (n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    cursor += TW'($urandom_range(1, 3000));
                else if (pick < 80)
                    cursor += TW'($urandom_range(3000, 1 << 22));
                else if (pick < 87)
                    cursor -= TW'($urandom_range(1, 2000));
                else if (pick < 92)
                    cursor += TW'($urandom_range(1 << 22, 1 << 25));
                stamp = cursor;
                if (ph % 4 == 1 && $urandom_range(0, 19) == 0)
                    stamp = TW'({$urandom, $urandom});

                pick = $urandom_range(0, 99);
                if (pick < 40)
                    lv = lv_on - lv_shift + int'($urandom_range(0, 8192)) - 4096;
                else if (pick < 75)
                    lv = lv_off - lv_shift + int'($urandom_range(0, 8192)) - 4096;
                else if (pick < 90)
                    lv = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0: lv = 32'h7fff_ffff;
                        1: lv = 32'h8000_0000;
                        2: lv = 0;
                        default: lv = -1;
                    endcase
                end
                queue_sample(stamp, lv);
            end
        end

        // full-range jumps drive both totals into saturation
        wait_drained();
        write_reg(dchm_pkg::REG_ON_LEVEL, level_word(32'h8000_0000));
        write_reg(dchm_pkg::REG_OFF_LEVEL, level_word(32'h8000_0000));
        write_reg(dchm_pkg::REG_LEVEL_OFFSET, level_word(0));
        write_reg(dchm_pkg::REG_WINDOW_START, '0);
        write_reg(dchm_pkg::REG_WINDOW_END, TOP_TIME);
        queue_sample('0, 32'h7fff_ffff);
        queue_sample(TOP_TIME, 1);
        queue_sample(TOP_TIME, 32'h8000_0000);
        wait_drained();

        if (duty_expected.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
